>>> design/smo_pkg.sv
// Shared types and constants for the stack machine block.
// Used by the request/response interfaces, the controller, the datapath and the top level.
`default_nettype none

package smo_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int WORD_W      = 32;
  localparam int LINE_W      = 16;
  localparam int CMD_W       = 3;
  localparam int KIND_W      = 2;
  localparam int CODE_W      = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 3'd0,
    CMD_LIST = 3'd1,
    CMD_PEEK = 3'd2,
    CMD_POP  = 3'd3,
    CMD_SWAP = 3'd4,
    CMD_ADD  = 3'd5
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_END  = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  typedef enum logic [CODE_W-1:0] {
    ERR_NONE       = 3'd0,
    ERR_PEEK_EMPTY = 3'd1,
    ERR_POP_EMPTY  = 3'd2,
    ERR_SWAP_SHORT = 3'd3,
    ERR_ADD_SHORT  = 3'd4,
    ERR_HALTED     = 3'd5,
    ERR_PUSH_FULL  = 3'd6
  } err_t;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,
    DP_PUSH,
    DP_POP,
    DP_ADD,
    DP_SWAP1,
    DP_SWAP2,
    DP_LIST_STEP
  } dp_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWAP,
    ST_LIST
  } state_t;

  typedef struct packed {
    dp_op_t op;
    logic   in_list;
    logic   emit;
    kind_t  kind;
    err_t   code;
    logic   last;
    logic   sel_top;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic empty;
    logic few_entries;
    logic full;
    logic list_done;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> design/smo_in_if.sv
// Request channel of the stack machine: one command per request.
// Depends on smo_pkg for field widths.
`default_nettype none

interface smo_in_if;
  logic                              valid;
  logic                              ready;
  logic [smo_pkg::CMD_W-1:0]         cmd;
  logic signed [smo_pkg::WORD_W-1:0] push_value;
  logic [smo_pkg::LINE_W-1:0]        line_tag;

  modport source (output valid, output cmd, output push_value, output line_tag, input ready);
  modport sink (input valid, input cmd, input push_value, input line_tag, output ready);
endinterface

`default_nettype wire

>>> design/smo_out_if.sv
// Response channel of the stack machine: one result per response beat.
// Depends on smo_pkg for field widths.
`default_nettype none

interface smo_out_if;
  logic                              valid;
  logic                              ready;
  logic [smo_pkg::KIND_W-1:0]        kind;
  logic signed [smo_pkg::WORD_W-1:0] data_value;
  logic [smo_pkg::CODE_W-1:0]        error_code;
  logic [smo_pkg::LINE_W-1:0]        error_line;
  logic                              last;

  modport source (output valid, output kind, output data_value, output error_code,
                  output error_line, output last, input ready);
  modport sink (input valid, input kind, input data_value, input error_code,
                input error_line, input last, output ready);
endinterface

`default_nettype wire

>>> design/smo_dp.sv
// Stack machine datapath: stack memory, entry count, listing pointer,
// request latch and response register. Driven by smo_ctrl; depends on smo_pkg.
`default_nettype none

module smo_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire smo_pkg::dp_cmd_t                  cmd,
  output smo_pkg::dp_stat_t                      stat,
  input  wire logic [smo_pkg::CMD_W-1:0]         item_cmd_in,
  input  wire logic signed [smo_pkg::WORD_W-1:0] item_value_in,
  input  wire logic [smo_pkg::LINE_W-1:0]        item_line_in,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output logic [smo_pkg::KIND_W-1:0]             out_kind,
  output logic signed [smo_pkg::WORD_W-1:0]      out_data,
  output logic [smo_pkg::CODE_W-1:0]             out_code,
  output logic [smo_pkg::LINE_W-1:0]             out_line,
  output logic                                   out_last
);

  logic [smo_pkg::WORD_W-1:0] mem [smo_pkg::STACK_DEPTH];

  smo_pkg::cmd_t              item_cmd;
  logic [smo_pkg::WORD_W-1:0] item_value;
  logic [smo_pkg::LINE_W-1:0] item_line;
  logic [smo_pkg::CNT_W-1:0]  count;
  logic [smo_pkg::CNT_W-1:0]  count_next;
  logic [smo_pkg::CNT_W-1:0]  ptr;
  logic [smo_pkg::CNT_W-1:0]  ptr_next;
  logic [smo_pkg::WORD_W-1:0] rd_a;
  logic [smo_pkg::WORD_W-1:0] rd_b;
  logic [smo_pkg::WORD_W-1:0] tmp;
  logic [smo_pkg::CNT_W-1:0]  ra_full;
  logic [smo_pkg::CNT_W-1:0]  rb_full;
  logic [smo_pkg::ADDR_W-1:0] rd_addr_a;
  logic [smo_pkg::ADDR_W-1:0] rd_addr_b;
  logic                       wr_en;
  logic [smo_pkg::CNT_W-1:0]  wr_full;
  logic [smo_pkg::WORD_W-1:0] wr_data;
  logic                       out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    count_next = count;
    wr_en      = 1'b0;
    wr_full    = count;
    wr_data    = item_value;
    unique case (cmd.op)
      smo_pkg::DP_PUSH: begin
        wr_en      = 1'b1;
        wr_full    = count;
        wr_data    = item_value;
        count_next = count + smo_pkg::CNT_W'(1);
      end
      smo_pkg::DP_POP: begin
        count_next = count - smo_pkg::CNT_W'(1);
      end
      smo_pkg::DP_ADD: begin
        wr_en      = 1'b1;
        wr_full    = count - smo_pkg::CNT_W'(2);
        wr_data    = rd_a + rd_b;
        count_next = count - smo_pkg::CNT_W'(1);
      end
      smo_pkg::DP_SWAP1: begin
        wr_en   = 1'b1;
        wr_full = count - smo_pkg::CNT_W'(1);
        wr_data = rd_b;
      end
      smo_pkg::DP_SWAP2: begin
        wr_en   = 1'b1;
        wr_full = count - smo_pkg::CNT_W'(2);
        wr_data = tmp;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (cmd.op == smo_pkg::DP_LIST_STEP) begin
      ptr_next = ptr - smo_pkg::CNT_W'(1);
    end else if (cmd.in_list) begin
      ptr_next = ptr;
    end else begin
      ptr_next = count_next;
    end
    ra_full   = ptr_next - smo_pkg::CNT_W'(1);
    rb_full   = ptr_next - smo_pkg::CNT_W'(2);
    rd_addr_a = ra_full[smo_pkg::ADDR_W-1:0];
    rd_addr_b = rb_full[smo_pkg::ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_full[smo_pkg::ADDR_W-1:0]] <= wr_data;
    end
    rd_a <= mem[rd_addr_a];
    rd_b <= mem[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ptr   <= '0;
    end else begin
      count <= count_next;
      ptr   <= ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == smo_pkg::DP_LOAD) begin
      item_cmd   <= smo_pkg::cmd_t'(item_cmd_in);
      item_value <= item_value_in;
      item_line  <= item_line_in;
    end
    if (cmd.op == smo_pkg::DP_SWAP1) begin
      tmp <= rd_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind <= cmd.kind;
      out_data <= cmd.sel_top ? rd_a : '0;
      out_code <= cmd.code;
      out_line <= (cmd.kind == smo_pkg::KIND_ERR) ? item_line : '0;
      out_last <= cmd.last;
    end
  end

  always_comb begin
    stat.cmd         = item_cmd;
    stat.empty       = (count == '0);
    stat.few_entries = (count < smo_pkg::CNT_W'(2));
    stat.full        = (count >= smo_pkg::CNT_W'(smo_pkg::STACK_DEPTH));
    stat.list_done   = (ptr == '0);
    stat.out_free    = out_free;
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= smo_pkg::CNT_W'(smo_pkg::STACK_DEPTH))
    else $error("entry count beyond stack depth");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    ptr <= count)
    else $error("listing pointer above entry count");
`endif

endmodule

`default_nettype wire

>>> design/smo_ctrl.sv
// Stack machine controller: request sequencing, error checks and halt state.
// Drives smo_dp through dp_cmd_t and reads dp_stat_t; depends on smo_pkg.
`default_nettype none

module smo_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire smo_pkg::dp_stat_t stat,
  output smo_pkg::dp_cmd_t       cmd
);

  smo_pkg::state_t state;
  smo_pkg::state_t state_next;
  logic            halted;
  logic            halted_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= smo_pkg::ST_IDLE;
      halted <= 1'b0;
    end else begin
      state  <= state_next;
      halted <= halted_next;
    end
  end

  always_comb begin
    state_next  = state;
    halted_next = halted;
    in_ready    = 1'b0;
    cmd.op      = smo_pkg::DP_NOP;
    cmd.in_list = 1'b0;
    cmd.emit    = 1'b0;
    cmd.kind    = smo_pkg::KIND_ACK;
    cmd.code    = smo_pkg::ERR_NONE;
    cmd.last    = 1'b1;
    cmd.sel_top = 1'b0;
    unique case (state)
      smo_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = smo_pkg::DP_LOAD;
          state_next = smo_pkg::ST_EXEC;
        end
      end
      smo_pkg::ST_EXEC: begin
        if (stat.out_free) begin
          state_next = smo_pkg::ST_IDLE;
          cmd.emit   = 1'b1;
          if (halted) begin
            cmd.kind = smo_pkg::KIND_ERR;
            cmd.code = smo_pkg::ERR_HALTED;
          end else begin
            unique case (stat.cmd)
              smo_pkg::CMD_PUSH: begin
                if (stat.full) begin
                  cmd.kind = smo_pkg::KIND_ERR;
                  cmd.code = smo_pkg::ERR_PUSH_FULL;
                end else begin
                  cmd.op = smo_pkg::DP_PUSH;
                end
              end
              smo_pkg::CMD_LIST: begin
                cmd.emit    = 1'b0;
                cmd.in_list = 1'b1;
                state_next  = smo_pkg::ST_LIST;
              end
              smo_pkg::CMD_PEEK: begin
                if (stat.empty) begin
                  cmd.kind = smo_pkg::KIND_ERR;
                  cmd.code = smo_pkg::ERR_PEEK_EMPTY;
                end else begin
                  cmd.kind    = smo_pkg::KIND_DATA;
                  cmd.sel_top = 1'b1;
                end
              end
              smo_pkg::CMD_POP: begin
                if (stat.empty) begin
                  cmd.kind = smo_pkg::KIND_ERR;
                  cmd.code = smo_pkg::ERR_POP_EMPTY;
                end else begin
                  cmd.op = smo_pkg::DP_POP;
                end
              end
              smo_pkg::CMD_SWAP: begin
                if (stat.few_entries) begin
                  cmd.kind = smo_pkg::KIND_ERR;
                  cmd.code = smo_pkg::ERR_SWAP_SHORT;
                end else begin
                  cmd.op     = smo_pkg::DP_SWAP1;
                  cmd.emit   = 1'b0;
                  state_next = smo_pkg::ST_SWAP;
                end
              end
              smo_pkg::CMD_ADD: begin
                if (stat.few_entries) begin
                  cmd.kind = smo_pkg::KIND_ERR;
                  cmd.code = smo_pkg::ERR_ADD_SHORT;
                end else begin
                  cmd.op = smo_pkg::DP_ADD;
                end
              end
              default: begin
              end
            endcase
          end
          if (cmd.emit && cmd.kind == smo_pkg::KIND_ERR) begin
            halted_next = 1'b1;
          end
        end
      end
      smo_pkg::ST_SWAP: begin
        if (stat.out_free) begin
          cmd.op     = smo_pkg::DP_SWAP2;
          cmd.emit   = 1'b1;
          state_next = smo_pkg::ST_IDLE;
        end
      end
      smo_pkg::ST_LIST: begin
        cmd.in_list = 1'b1;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.list_done) begin
            cmd.in_list = 1'b0;
            cmd.kind    = smo_pkg::KIND_END;
            state_next  = smo_pkg::ST_IDLE;
          end else begin
            cmd.op      = smo_pkg::DP_LIST_STEP;
            cmd.kind    = smo_pkg::KIND_DATA;
            cmd.sel_top = 1'b1;
            cmd.last    = 1'b0;
          end
        end
      end
      default: begin
        state_next = smo_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt cleared without reset");

  a_err_halts: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.kind == smo_pkg::KIND_ERR) |=> halted)
    else $error("error response without halt");

  a_halt_no_change: assert property (@(posedge clk) disable iff (rst)
    halted |-> (cmd.op == smo_pkg::DP_NOP || cmd.op == smo_pkg::DP_LOAD))
    else $error("stack modified while halted");
`endif

endmodule

`default_nettype wire

>>> design/stack_machine_ops_top.sv
// Top level of the stack machine: joins controller and datapath to the channels.
// Depends on smo_pkg, smo_in_if, smo_out_if, smo_ctrl and smo_dp.
//
// A request carries one stack command (push, list, peek, pop, swap, add) and is
// taken only while the block is idle; the stack lives in a memory with one write
// port and two registered read ports that read the top two entries (in a listing,
// the two below the pointer). Push, pop, peek, add and unused codes pass accept
// and execute; a swap adds a second write step, as its writes share the write
// port. A listing returns each entry, then an end marker, one per cycle while the
// response channel is free. A new request can be taken while the previous response
// still waits in the output register. After any error every request answers with
// a halted error until reset. No clearing pass is needed after reset.
`default_nettype none

module stack_machine_ops_top (
  input  wire logic  clk,
  input  wire logic  rst,
  smo_in_if.sink     req,
  smo_out_if.source  rsp
);

  smo_pkg::dp_cmd_t  cmd;
  smo_pkg::dp_stat_t stat;
  logic              in_ready;

  assign req.ready = in_ready;

  smo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  smo_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .item_cmd_in   (req.cmd),
    .item_value_in (req.push_value),
    .item_line_in  (req.line_tag),
    .out_ready     (rsp.ready),
    .out_valid     (rsp.valid),
    .out_kind      (rsp.kind),
    .out_data      (rsp.data_value),
    .out_code      (rsp.error_code),
    .out_line      (rsp.error_line),
    .out_last      (rsp.last)
  );

endmodule

`default_nettype wire
